// ===== sv/prht_pkg.sv =====
// Shared constants, table entry layout and controller/datapath command and status types.
package prht_pkg;

    // Table size and derived widths.
    localparam int MAX_REGIONS = 16;
    localparam int ADDR_W      = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int SCAN_W      = (CNT_W > 5) ? CNT_W : 5;

    // Field widths.
    localparam int COORD_W = 10;
    localparam int IMAGE_W = 8;
    localparam int HOT_W   = 16;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;

    // Item kinds carried in the mode field.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // One table entry as held in the region memory.
    typedef struct packed {
        logic [HOT_W-1:0]   hotspot;
        logic [IMAGE_W-1:0] image;
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic load;
        logic scan;
        logic pick_hit;
        logic pick_def;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/prht_req_if.sv =====
// Input channel: write and query beats.
interface prht_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [prht_pkg::IDX_W-1:0]    entry_index;
    logic [prht_pkg::COORD_W-1:0]  left;
    logic [prht_pkg::COORD_W-1:0]  top;
    logic [prht_pkg::COORD_W-1:0]  right;
    logic [prht_pkg::COORD_W-1:0]  bottom;
    logic [prht_pkg::IMAGE_W-1:0]  entry_image;
    logic [prht_pkg::HOT_W-1:0]    entry_hotspot;
    logic [prht_pkg::COORD_W-1:0]  pos_x;
    logic [prht_pkg::COORD_W-1:0]  pos_y;

    modport source (
        output valid, mode, entry_index, left, top, right, bottom,
               entry_image, entry_hotspot, pos_x, pos_y,
        input  ready
    );

    modport sink (
        input  valid, mode, entry_index, left, top, right, bottom,
               entry_image, entry_hotspot, pos_x, pos_y,
        output ready
    );
endinterface

// ===== sv/prht_rsp_if.sv =====
// Result channel: one beat per query.
interface prht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [prht_pkg::IMAGE_W-1:0]  pointer_image;
    logic [prht_pkg::HOT_W-1:0]    pointer_hotspot;
    logic [prht_pkg::IMAGE_W-1:0]  previous_image;
    logic [prht_pkg::IDX_W-1:0]    region_index;

    modport source (
        output valid, pointer_image, pointer_hotspot, previous_image, region_index,
        input  ready
    );

    modport sink (
        input  valid, pointer_image, pointer_hotspot, previous_image, region_index,
        output ready
    );
endinterface

// ===== sv/prht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/prht_ctrl.sv =====
// Controller: sequences table writes, the region scan and the result hand-off.
module prht_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    output logic            in_ready,
    output prht_pkg::cmd_t  cmd,
    input  prht_pkg::stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == prht_pkg::MODE_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.pick_hit = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (stat.scan_end)
                begin
                    cmd.pick_def = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A match ends the scan and the result waits for the output register.
    a_hit_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stat.hit) |=> (state_reg == ST_DONE))
        else $error("scan hit did not move to result hand-off");

    // A scan picks either a match or the default, never both.
    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pick_hit && cmd.pick_def))
        else $error("match and default picked together");

    // The result is committed only when the output register can take it.
    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result committed while the output register was busy");
`endif

endmodule

// ===== sv/prht_datapath.sv =====
// Datapath: region memory, scan pointer, hit compare and result registers.
module prht_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [prht_pkg::COUNT_W-1:0]  cfg_data,
    input  prht_pkg::cmd_t                cmd,
    output prht_pkg::stat_t               stat,
    input  logic [prht_pkg::IDX_W-1:0]    entry_index,
    input  logic [prht_pkg::COORD_W-1:0]  left,
    input  logic [prht_pkg::COORD_W-1:0]  top,
    input  logic [prht_pkg::COORD_W-1:0]  right,
    input  logic [prht_pkg::COORD_W-1:0]  bottom,
    input  logic [prht_pkg::IMAGE_W-1:0]  entry_image,
    input  logic [prht_pkg::HOT_W-1:0]    entry_hotspot,
    input  logic [prht_pkg::COORD_W-1:0]  pos_x,
    input  logic [prht_pkg::COORD_W-1:0]  pos_y,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [prht_pkg::IMAGE_W-1:0]  pointer_image,
    output logic [prht_pkg::HOT_W-1:0]    pointer_hotspot,
    output logic [prht_pkg::IMAGE_W-1:0]  previous_image,
    output logic [prht_pkg::IDX_W-1:0]    region_index
);

    localparam logic [prht_pkg::SCAN_W-1:0] MAX_CNT =
        prht_pkg::SCAN_W'(prht_pkg::MAX_REGIONS);
    localparam logic [prht_pkg::SCAN_W-1:0] ONE_CNT = prht_pkg::SCAN_W'(1);

    // Control registers.
    logic [prht_pkg::COUNT_W-1:0] count_reg,     count_next;
    logic [prht_pkg::SCAN_W-1:0]  limit_reg,     limit_next;
    logic [prht_pkg::SCAN_W-1:0]  ptr_reg,       ptr_next;
    logic [prht_pkg::SCAN_W-1:0]  rd_idx_reg,    rd_idx_next;
    logic                         rd_vld_reg,    rd_vld_next;
    logic [prht_pkg::IMAGE_W-1:0] cur_image_reg, cur_image_next;
    logic                         out_valid_reg, out_valid_next;

    // Payload registers.
    logic [prht_pkg::COORD_W-1:0] px_reg,        px_next;
    logic [prht_pkg::COORD_W-1:0] py_reg,        py_next;
    logic [prht_pkg::IMAGE_W-1:0] def_image_reg, def_image_next;
    logic [prht_pkg::HOT_W-1:0]   def_hot_reg,   def_hot_next;
    logic [prht_pkg::IMAGE_W-1:0] sel_image_reg, sel_image_next;
    logic [prht_pkg::HOT_W-1:0]   sel_hot_reg,   sel_hot_next;
    logic [prht_pkg::SCAN_W-1:0]  sel_idx_reg,   sel_idx_next;
    logic [prht_pkg::IMAGE_W-1:0] out_image_reg, out_image_next;
    logic [prht_pkg::HOT_W-1:0]   out_hot_reg,   out_hot_next;
    logic [prht_pkg::IMAGE_W-1:0] out_prev_reg,  out_prev_next;
    logic [prht_pkg::IDX_W-1:0]   out_idx_reg,   out_idx_next;

    logic [prht_pkg::SCAN_W-1:0]  count_ext;
    logic [prht_pkg::SCAN_W-1:0]  limit_calc;
    logic [prht_pkg::SCAN_W-1:0]  wr_ext;
    logic                         wr_en;
    logic                         issue;
    logic                         in_region;
    prht_pkg::entry_t             wr_entry;
    prht_pkg::entry_t             rd_entry;

    // Effective entry count: zero acts as one, large values saturate.
    assign count_ext  = prht_pkg::SCAN_W'(count_reg);
    assign limit_calc = (count_ext == '0)     ? ONE_CNT :
                        (count_ext > MAX_CNT) ? MAX_CNT : count_ext;

    // Table write, ignored for indexes beyond the table.
    assign wr_ext   = prht_pkg::SCAN_W'(entry_index);
    assign wr_en    = cmd.store && (wr_ext < MAX_CNT);
    assign wr_entry = '{hotspot: entry_hotspot, image: entry_image, bottom: bottom,
                        right: right, top: top, left: left};

    // One read is issued per scan cycle until the entry count is reached.
    assign issue = cmd.scan && (ptr_reg < limit_reg);

    prht_ram #(
        .WIDTH (prht_pkg::ENTRY_W),
        .DEPTH (prht_pkg::MAX_REGIONS)
    ) u_region_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ext[prht_pkg::ADDR_W-1:0]),
        .wdata (wr_entry),
        .raddr (ptr_reg[prht_pkg::ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    // Strict containment test on the entry just read.
    assign in_region = (px_reg > rd_entry.left) && (px_reg < rd_entry.right) &&
                       (py_reg > rd_entry.top)  && (py_reg < rd_entry.bottom);

    assign stat.hit      = rd_vld_reg && (rd_idx_reg != '0) && in_region;
    assign stat.scan_end = !rd_vld_reg && (ptr_reg >= limit_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Next-state logic for all registers.
    always_comb
    begin
        count_next     = cfg_we ? cfg_data : count_reg;
        limit_next     = limit_reg;
        ptr_next       = ptr_reg;
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = 1'b0;
        px_next        = px_reg;
        py_next        = py_reg;
        def_image_next = def_image_reg;
        def_hot_next   = def_hot_reg;
        sel_image_next = sel_image_reg;
        sel_hot_next   = sel_hot_reg;
        sel_idx_next   = sel_idx_reg;
        cur_image_next = cur_image_reg;
        out_image_next = out_image_reg;
        out_hot_next   = out_hot_reg;
        out_prev_next  = out_prev_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        // Start of a query: latch position and count, rewind the pointer.
        if (cmd.load)
        begin
            px_next    = pos_x;
            py_next    = pos_y;
            limit_next = limit_calc;
            ptr_next   = '0;
        end

        // Scan step: advance the read pointer.
        if (issue)
        begin
            rd_vld_next = 1'b1;
            rd_idx_next = ptr_reg;
            ptr_next    = ptr_reg + ONE_CNT;
        end

        // The default entry is read first and kept aside.
        if (rd_vld_reg && (rd_idx_reg == '0))
        begin
            def_image_next = rd_entry.image;
            def_hot_next   = rd_entry.hotspot;
        end

        // Selection of the winning entry.
        if (cmd.pick_hit)
        begin
            sel_image_next = rd_entry.image;
            sel_hot_next   = rd_entry.hotspot;
            sel_idx_next   = rd_idx_reg;
        end
        else if (cmd.pick_def)
        begin
            sel_image_next = def_image_reg;
            sel_hot_next   = def_hot_reg;
            sel_idx_next   = '0;
        end

        // Result beat into the output register; the current shape moves on.
        if (cmd.finish)
        begin
            out_image_next = sel_image_reg;
            out_hot_next   = sel_hot_reg;
            out_prev_next  = cur_image_reg;
            out_idx_next   = sel_idx_reg[prht_pkg::IDX_W-1:0];
            cur_image_next = sel_image_reg;
            out_valid_next = 1'b1;
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= prht_pkg::COUNT_W'(1);
            limit_reg     <= ONE_CNT;
            ptr_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            cur_image_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            ptr_reg       <= ptr_next;
            rd_idx_reg    <= rd_idx_next;
            rd_vld_reg    <= rd_vld_next;
            cur_image_reg <= cur_image_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        def_image_reg <= def_image_next;
        def_hot_reg   <= def_hot_next;
        sel_image_reg <= sel_image_next;
        sel_hot_reg   <= sel_hot_next;
        sel_idx_reg   <= sel_idx_next;
        out_image_reg <= out_image_next;
        out_hot_reg   <= out_hot_next;
        out_prev_reg  <= out_prev_next;
        out_idx_reg   <= out_idx_next;
    end

    assign out_valid       = out_valid_reg;
    assign pointer_image   = out_image_reg;
    assign pointer_hotspot = out_hot_reg;
    assign previous_image  = out_prev_reg;
    assign region_index    = out_idx_reg;

`ifndef SYNTH
    // A result beat appears only when the controller commits one.
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result beat raised without a commit");

    // A commit never overwrites a result that has not been taken.
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while stalled");

    // The effective count stays within the table.
    a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (limit_reg >= ONE_CNT) && (limit_reg <= MAX_CNT))
        else $error("effective entry count out of range");

    // Every read in flight lies below the effective count.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (rd_idx_reg < limit_reg))
        else $error("scan read beyond the entries in use");
`endif

endmodule

// ===== sv/pointer_region_hit_test.sv =====
// Pointer region hit test: top level joining controller, datapath and interfaces.
//
// The req channel carries two kinds of beat. A write beat (mode 0) loads one
// table entry: four exclusive edges, an image number and a hotspot word. It
// is taken while idle and gives no result. A query beat (mode 1) carries
// a pointer position; entries 1 to region_count-1 are tested in order, the
// first one containing the position wins, else entry 0 is used. Each query
// gives one beat on the rsp channel with the new image and hotspot, the
// image in effect before, and the chosen index.
// A query walks the region memory one entry per cycle through its single
// read port, stopping at the first match or after n entries, n being
// region_count with zero taken as one and values above 16 as 16; no new
// beat is taken until the result is committed. region_count is written
// through cfg_we/cfg_data; the user must do this only while idle, as the
// block itself does not enforce it. Reset clears the current image, sets
// region_count to 1 and empties the output register; table contents are
// undefined until written. If the receiver stalls, the result is held in
// the output register and the block still takes write beats, but holds the
// next query's result until the pending beat is taken.
module pointer_region_hit_test (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [prht_pkg::COUNT_W-1:0] cfg_data,
    prht_req_if.sink                     req,
    prht_rsp_if.source                   rsp
);

    prht_pkg::cmd_t  cmd;
    prht_pkg::stat_t stat;
    logic            in_ready;

    // Sequencer.
    prht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign req.ready = in_ready;

    // Table, scan and result registers.
    prht_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .entry_index     (req.entry_index),
        .left            (req.left),
        .top             (req.top),
        .right           (req.right),
        .bottom          (req.bottom),
        .entry_image     (req.entry_image),
        .entry_hotspot   (req.entry_hotspot),
        .pos_x           (req.pos_x),
        .pos_y           (req.pos_y),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .pointer_image   (rsp.pointer_image),
        .pointer_hotspot (rsp.pointer_hotspot),
        .previous_image  (rsp.previous_image),
        .region_index    (rsp.region_index)
    );

endmodule

// ===== test/pointer_region_hit_check.sv =====
// Checker for the pointer region hit test: tracks the region table and compares every result beat.
module pointer_region_hit_check
    import prht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    prht_req_if                req,
    prht_rsp_if                rsp,
    output int                 mismatches,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat: new shape, shape before the query and the chosen entry.
    typedef struct packed {
        logic [IMAGE_W-1:0] image;
        logic [HOT_W-1:0]   hotspot;
        logic [IMAGE_W-1:0] prev_image;
        logic [IDX_W-1:0]   index;
    } shape_t;

    entry_t             regions [MAX_REGIONS];
    logic [COUNT_W-1:0] region_count;
    logic [IMAGE_W-1:0] cur_image;
    logic [HOT_W-1:0]   cur_hotspot;
    shape_t             shapes_due [$];
    int                 shapes_seen;

    // Lowest-numbered entry in use that strictly contains the position, else the default.
    function automatic int first_hit(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, int used);
        for (int i = 1; i < used; i++)
        begin
            if (x > regions[i].left && x < regions[i].right &&
                y > regions[i].top && y < regions[i].bottom)
                return i;
        end
        return 0;
    endfunction

    // Follow configuration, table writes and queries; compare result beats in order.
    always @(posedge clk or negedge rst_n)
    begin : track
        shape_t want;
        shape_t got;
        int     used;
        int     hit;

        if (!rst_n)
        begin
            region_count = 1;
            cur_image    = '0;
            cur_hotspot  = '0;
            shapes_due.delete();
            pending      = 0;
            mismatches   = 0;
            shapes_seen  = 0;
        end
        else
        begin
            if (cfg_we)
                region_count = cfg_data;

            // A result beat is matched against the oldest outstanding query.
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.pointer_image, rsp.pointer_hotspot, rsp.previous_image,
                        rsp.region_index};
                shapes_seen++;
                if (shapes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d arrived with no query waiting: image %0d hotspot %h prev %0d index %0d",
                                 shapes_seen, got.image, got.hotspot, got.prev_image, got.index);
                end
                else
                begin
                    want = shapes_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result beat %0d wrong: expected image %0d hotspot %h prev %0d index %0d, got image %0d hotspot %h prev %0d index %0d",
                                     shapes_seen, want.image, want.hotspot, want.prev_image,
                                     want.index, got.image, got.hotspot, got.prev_image,
                                     got.index);
                    end
                end
            end

            // An accepted input beat either loads an entry or queues the expected shape.
            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_WRITE)
                begin
                    regions[req.entry_index] = '{hotspot: req.entry_hotspot,
                                                 image:   req.entry_image,
                                                 bottom:  req.bottom,
                                                 right:   req.right,
                                                 top:     req.top,
                                                 left:    req.left};
                end
                else
                begin
                    used = (region_count == 0) ? 1 :
                           (region_count > MAX_REGIONS) ? MAX_REGIONS : int'(region_count);
                    hit = first_hit(req.pos_x, req.pos_y, used);
                    want.prev_image = cur_image;
                    cur_image       = regions[hit].image;
                    cur_hotspot     = regions[hit].hotspot;
                    want.image      = cur_image;
                    want.hotspot    = cur_hotspot;
                    want.index      = IDX_W'(hit);
                    shapes_due.push_back(want);
                end
            end

            pending = shapes_due.size();
        end
    end

endmodule

// ===== test/pointer_region_hit_test_tb.sv =====
// Testbench top for the pointer region hit test: clock, reset, stimulus and verdict.
module pointer_region_hit_test_tb;
    import prht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int SETTLE_TICKS = 24;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 205;

    // One input beat as the sender builds it.
    typedef struct {
        logic             mode;
        logic [IDX_W-1:0] entry_index;
        entry_t           ent;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } req_beat_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;
    int                 mismatches;
    int                 pending;

    // Sender state and a shadow of the table, used only to aim query positions.
    entry_t shadow [MAX_REGIONS];
    int     count_in_use = 1;
    int     burst_left   = 0;
    bit     quiet        = 1'b0;
    int     cycles       = 0;

    prht_req_if req_ch ();
    prht_rsp_if rsp_ch ();

    pointer_region_hit_test dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    pointer_region_hit_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver's ready follows a 16-bit random mask with at least one bit set, and is held high in quiet phases.
    initial
    begin : receiver
        logic [15:0] stall_mask;
        int          tick;

        rsp_ch.ready <= 1'b0;
        stall_mask = 16'hFFFF;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (tick % 64 == 0)
                stall_mask = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
            rsp_ch.ready <= quiet || stall_mask[tick % 16];
            tick++;
        end
    end

    // Fixed table for the opening checks: overlaps, an inverted and an empty
    // region, a row of small regions and a whole-screen region last.
    function automatic entry_t directed_entry(int i);
        entry_t e;

        e.image   = (i == 0) ? 8'hFF : (i == 15) ? 8'h00 : IMAGE_W'(i * 13);
        e.hotspot = (i == 0) ? 16'hFFFF : (i == 15) ? 16'h0000 : HOT_W'(i * 16'h0F0F);
        case (i)
            0, 15:   e = '{hotspot: e.hotspot, image: e.image, bottom: 1023, right: 1023,
                           top: 0, left: 0};
            1:       e = '{hotspot: e.hotspot, image: e.image, bottom: 200, right: 200,
                           top: 100, left: 100};
            2:       e = '{hotspot: e.hotspot, image: e.image, bottom: 300, right: 300,
                           top: 150, left: 150};
            3:       e = '{hotspot: e.hotspot, image: e.image, bottom: 400, right: 400,
                           top: 500, left: 500};
            4:       e = '{hotspot: e.hotspot, image: e.image, bottom: 601, right: 601,
                           top: 600, left: 600};
            5:       e = '{hotspot: e.hotspot, image: e.image, bottom: 1023, right: 1023,
                           top: 1000, left: 1000};
            default: e = '{hotspot: e.hotspot, image: e.image, bottom: 950,
                           right: COORD_W'((i - 6) * 100 + 50), top: 900,
                           left: COORD_W'((i - 6) * 100)};
        endcase
        return e;
    endfunction

    // Random region: mostly sensible rectangles, some degenerate, some raw bits, some whole-screen.
    function automatic entry_t random_entry();
        entry_t e;
        int     kind;

        kind = $urandom_range(0, 9);
        e.image   = IMAGE_W'($urandom);
        e.hotspot = HOT_W'($urandom);
        case (kind)
            0:
            begin
                e.left   = COORD_W'($urandom_range(0, 1022));
                e.right  = COORD_W'($urandom_range(0, e.left + 1));
                e.top    = COORD_W'($urandom_range(0, 1022));
                e.bottom = COORD_W'($urandom_range(0, e.top + 1));
            end
            1:
            begin
                e.left   = COORD_W'($urandom);
                e.right  = COORD_W'($urandom);
                e.top    = COORD_W'($urandom);
                e.bottom = COORD_W'($urandom);
            end
            2:
            begin
                e.left   = 0;
                e.top    = 0;
                e.right  = 1023;
                e.bottom = 1023;
            end
            default:
            begin
                e.left   = COORD_W'($urandom_range(0, 860));
                e.right  = e.left + COORD_W'($urandom_range(2, 160));
                e.top    = COORD_W'($urandom_range(0, 860));
                e.bottom = e.top + COORD_W'($urandom_range(2, 160));
            end
        endcase
        return e;
    endfunction

    // One of the four coordinates around a pair of edges, wrapping at the screen border.
    function automatic logic [COORD_W-1:0] near_edge(logic [COORD_W-1:0] lo,
                                                     logic [COORD_W-1:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return lo + 1'b1;
            2:       return hi - 1'b1;
            default: return hi;
        endcase
    endfunction

    // Build a beat; queries are mostly aimed inside or on the edges of an entry in use.
    function automatic req_beat_t random_beat(bit is_write);
        req_beat_t b;
        entry_t    e;
        int        aim;

        b.mode        = is_write ? MODE_WRITE : MODE_QUERY;
        b.entry_index = IDX_W'($urandom_range(0, MAX_REGIONS - 1));
        b.ent         = random_entry();
        b.pos_x       = COORD_W'($urandom);
        b.pos_y       = COORD_W'($urandom);
        if (!is_write && count_in_use > 1)
        begin
            e   = shadow[$urandom_range(1, count_in_use - 1)];
            aim = $urandom_range(0, 9);
            if (aim < 6)
            begin
                if (e.right > e.left + 1)
                    b.pos_x = COORD_W'($urandom_range(e.left + 1, e.right - 1));
                if (e.bottom > e.top + 1)
                    b.pos_y = COORD_W'($urandom_range(e.top + 1, e.bottom - 1));
            end
            else if (aim < 8)
            begin
                b.pos_x = near_edge(e.left, e.right);
                b.pos_y = near_edge(e.top, e.bottom);
            end
        end
        if (!is_write && $urandom_range(0, 15) == 0)
        begin
            b.pos_x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            b.pos_y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end
        return b;
    endfunction

    // Offer one beat, opening a new burst after a random gap when the last one ran out.
    task automatic send_beat(input req_beat_t b);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= b.mode;
        req_ch.entry_index   <= b.entry_index;
        req_ch.left          <= b.ent.left;
        req_ch.top           <= b.ent.top;
        req_ch.right         <= b.ent.right;
        req_ch.bottom        <= b.ent.bottom;
        req_ch.entry_image   <= b.ent.image;
        req_ch.entry_hotspot <= b.ent.hotspot;
        req_ch.pos_x         <= b.pos_x;
        req_ch.pos_y         <= b.pos_y;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
        if (b.mode == MODE_WRITE)
            shadow[b.entry_index] = b.ent;
    endtask

    // Stop sending, wait for every result, then let a possible write finish.
    task automatic settle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_region_count(input logic [COUNT_W-1:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        count_in_use = (value == 0) ? 1 : (value > MAX_REGIONS) ? MAX_REGIONS : int'(value);
    endtask

    // Region count for each random phase, the extremes among them.
    function automatic logic [COUNT_W-1:0] phase_count(int ph);
        case (ph)
            0:       return 0;
            1:       return COUNT_W'($urandom_range(2, 15));
            2:       return 31;
            3:       return 2;
            4:       return COUNT_W'($urandom_range(17, 30));
            5:       return 1;
            6:       return 16;
            default: return COUNT_W'($urandom_range(0, 31));
        endcase
    endfunction

    initial
    begin : stimulus
        req_beat_t b;
        int        probe_x [8];
        int        probe_y [8];

        probe_x = '{180, 250, 450, 100, 0, 1023, 25, 1022};
        probe_y = '{180, 250, 450, 150, 0, 1023, 925, 1022};

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_WRITE;
        req_ch.entry_index   <= '0;
        req_ch.left          <= '0;
        req_ch.top           <= '0;
        req_ch.right         <= '0;
        req_ch.bottom        <= '0;
        req_ch.entry_image   <= '0;
        req_ch.entry_hotspot <= '0;
        req_ch.pos_x         <= '0;
        req_ch.pos_y         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table; with the reset count only the default can be chosen.
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            b = random_beat(1'b1);
            b.entry_index = IDX_W'(i);
            b.ent = directed_entry(i);
            send_beat(b);
        end
        b = random_beat(1'b0);
        b.pos_x = 150;
        b.pos_y = 150;
        send_beat(b);

        // Full table: overlap, inverted region, left edge, screen corners, whole screen.
        set_region_count(16);
        for (int i = 0; i < 8; i++)
        begin
            b = random_beat(1'b0);
            b.pos_x = COORD_W'(probe_x[i]);
            b.pos_y = COORD_W'(probe_y[i]);
            send_beat(b);
        end

        // Random phases, each under its own region count; some run without idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_region_count(phase_count(ph));
            quiet = (ph % 3 == 1);
            repeat (PHASE_BEATS)
                send_beat(random_beat($urandom_range(0, 9) < 3));
        end

        quiet = 1'b0;
        settle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/prht_pkg.sv
sv/prht_req_if.sv
sv/prht_rsp_if.sv
sv/prht_ram.sv
sv/prht_ctrl.sv
sv/prht_datapath.sv
sv/pointer_region_hit_test.sv
test/pointer_region_hit_check.sv
test/pointer_region_hit_test_tb.sv
